### src/fcsg_pkg.sv
// Shared constants, types and phase codes of the filled circle span generator.
`timescale 1ns / 1ps
package fcsg_pkg;

   localparam int COORD_W    = 16;
   localparam int COLOR_W    = 8;
   localparam int MAX_RADIUS = 31;
   localparam int CNT_W      = $clog2(MAX_RADIUS + 2);
   localparam int WALK_W     = CNT_W + 4;
   localparam int NUM_PHASE  = 4;
   localparam int PHASE_W    = 2;

   // Span slots of one walk step, in emission order.
   localparam logic [PHASE_W-1:0] PH_TOP     = 2'd0;
   localparam logic [PHASE_W-1:0] PH_BOTTOM  = 2'd1;
   localparam logic [PHASE_W-1:0] PH_SIDE_LO = 2'd2;
   localparam logic [PHASE_W-1:0] PH_SIDE_HI = 2'd3;

   typedef struct packed {
      logic signed [COORD_W-1:0] center_x;
      logic signed [COORD_W-1:0] center_y;
      logic signed [COORD_W-1:0] radius;
      logic [COLOR_W-1:0]        red;
      logic [COLOR_W-1:0]        green;
      logic [COLOR_W-1:0]        blue;
      logic [COLOR_W-1:0]        alpha;
   } circle_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] span_row;
      logic signed [COORD_W-1:0] span_left;
      logic signed [COORD_W-1:0] span_right;
      logic [COLOR_W-1:0]        out_red;
      logic [COLOR_W-1:0]        out_green;
      logic [COLOR_W-1:0]        out_blue;
      logic [COLOR_W-1:0]        out_alpha;
      logic                      rejected;
      logic                      last_span;
   } span_type;

   typedef struct packed {
      logic load;
      logic step;
      logic flush;
   } cmd_type;

   typedef struct packed {
      logic radius_ok;
      logic stage_busy;
      logic walk_end;
      logic out_free;
   } status_type;

endpackage

### src/fcsg_ifs.sv
// Valid/ready channel interfaces for circle commands and span results.
`timescale 1ns / 1ps
interface fcsg_req_if;
   logic                                      valid;
   logic                                      ready;
   logic signed [fcsg_pkg::COORD_W-1:0]       center_x;
   logic signed [fcsg_pkg::COORD_W-1:0]       center_y;
   logic signed [fcsg_pkg::COORD_W-1:0]       radius;
   logic [fcsg_pkg::COLOR_W-1:0]              red;
   logic [fcsg_pkg::COLOR_W-1:0]              green;
   logic [fcsg_pkg::COLOR_W-1:0]              blue;
   logic [fcsg_pkg::COLOR_W-1:0]              alpha;

   modport source (output valid, center_x, center_y, radius, red, green, blue, alpha,
                   input ready);
   modport sink (input valid, center_x, center_y, radius, red, green, blue, alpha,
                 output ready);
endinterface

interface fcsg_rsp_if;
   logic                                      valid;
   logic                                      ready;
   logic signed [fcsg_pkg::COORD_W-1:0]       span_row;
   logic signed [fcsg_pkg::COORD_W-1:0]       span_left;
   logic signed [fcsg_pkg::COORD_W-1:0]       span_right;
   logic [fcsg_pkg::COLOR_W-1:0]              out_red;
   logic [fcsg_pkg::COLOR_W-1:0]              out_green;
   logic [fcsg_pkg::COLOR_W-1:0]              out_blue;
   logic [fcsg_pkg::COLOR_W-1:0]              out_alpha;
   logic                                      rejected;
   logic                                      last_span;

   modport source (output valid, span_row, span_left, span_right, out_red, out_green,
                   out_blue, out_alpha, rejected, last_span,
                   input ready);
   modport sink (input valid, span_row, span_left, span_right, out_red, out_green,
                 out_blue, out_alpha, rejected, last_span,
                 output ready);
endinterface

### src/fcsg_ctrl.sv
// Controller state machine that sequences load, walk and final flush of a circle.
`timescale 1ns / 1ps
module fcsg_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  fcsg_pkg::status_type status,
   output fcsg_pkg::cmd_type    cmd
);
   import fcsg_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_RUN   = 2'd1;
   localparam logic [1:0] ST_FLUSH = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = status.radius_ok ? ST_RUN : ST_FLUSH;
            end
         end
         ST_RUN: begin
            if (!status.stage_busy) begin
               cmd.step = 1'b1;
               if (status.walk_end) begin
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_FLUSH: begin
            if (status.out_free) begin
               cmd.flush = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### src/fcsg_datapath.sv
// Midpoint walk registers, span selection, staging register and output register.
`timescale 1ns / 1ps
module fcsg_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  fcsg_pkg::circle_type   req_item,
   input  fcsg_pkg::cmd_type      cmd,
   output fcsg_pkg::status_type   status,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output fcsg_pkg::span_type     rsp_item
);
   import fcsg_pkg::*;

   logic signed [COORD_W-1:0] x_ff, x_in;
   logic signed [COORD_W-1:0] y_ff, y_in;
   logic [COLOR_W-1:0]        red_ff, red_in;
   logic [COLOR_W-1:0]        green_ff, green_in;
   logic [COLOR_W-1:0]        blue_ff, blue_in;
   logic [COLOR_W-1:0]        alpha_ff, alpha_in;
   logic [CNT_W-1:0]          cx_ff, cx_in;
   logic [CNT_W-1:0]          cy_ff, cy_in;
   logic signed [WALK_W-1:0]  df_ff, df_in;
   logic signed [WALK_W-1:0]  de_ff, de_in;
   logic signed [WALK_W-1:0]  dse_ff, dse_in;
   logic                      top_pend_ff, top_pend_in;
   logic [PHASE_W-1:0]        phase_ff, phase_in;
   span_type                  stage_ff, stage_in;
   logic                      stage_valid_ff, stage_valid_in;
   span_type                  out_ff, out_in;
   logic                      out_valid_ff, out_valid_in;

   logic signed [WALK_W-1:0]  r_walk;
   logic [COORD_W-1:0]        cx_ext, cy_ext;
   logic [NUM_PHASE-1:0]      en;
   logic [PHASE_W-1:0]        sel;
   logic                      found, more, emit, walk_update, out_free, out_load;
   logic [CNT_W-1:0]          cx_nxt, cy_nxt;
   span_type                  new_span;

   assign r_walk = WALK_W'(req_item.radius);
   assign cx_ext = COORD_W'(cx_ff);
   assign cy_ext = COORD_W'(cy_ff);

   assign en[PH_TOP]     = top_pend_ff && (cy_ff != '0);
   assign en[PH_BOTTOM]  = top_pend_ff && (cy_ff != '0);
   assign en[PH_SIDE_LO] = cx_ff != cy_ff;
   assign en[PH_SIDE_HI] = (cx_ff != cy_ff) && (cx_ff != '0);

   always_comb begin
      found = 1'b0;
      sel   = PH_TOP;
      more  = 1'b0;
      for (int i = 0; i < NUM_PHASE; i++) begin
         if (!found && en[i] && (PHASE_W'(i) >= phase_ff)) begin
            found = 1'b1;
            sel   = PHASE_W'(i);
         end
      end
      for (int i = 0; i < NUM_PHASE; i++) begin
         if (found && en[i] && (PHASE_W'(i) > sel)) begin
            more = 1'b1;
         end
      end
   end

   always_comb begin
      new_span           = '0;
      new_span.out_red   = red_ff;
      new_span.out_green = green_ff;
      new_span.out_blue  = blue_ff;
      new_span.out_alpha = alpha_ff;
      case (sel)
         PH_TOP: begin
            new_span.span_row   = y_ff + cy_ext;
            new_span.span_left  = x_ff - cx_ext;
            new_span.span_right = x_ff + cx_ext;
         end
         PH_BOTTOM: begin
            new_span.span_row   = y_ff - cy_ext;
            new_span.span_left  = x_ff - cx_ext;
            new_span.span_right = x_ff + cx_ext;
         end
         PH_SIDE_LO: begin
            new_span.span_row   = y_ff - cx_ext;
            new_span.span_left  = x_ff - cy_ext;
            new_span.span_right = x_ff + cy_ext;
         end
         PH_SIDE_HI: begin
            new_span.span_row   = y_ff + cx_ext;
            new_span.span_left  = x_ff - cy_ext;
            new_span.span_right = x_ff + cy_ext;
         end
         default: begin
            new_span.span_row = y_ff;
         end
      endcase
   end

   assign cx_nxt      = cx_ff + 1'b1;
   assign cy_nxt      = df_ff[WALK_W-1] ? cy_ff : cy_ff - 1'b1;
   assign emit        = cmd.step && found;
   assign walk_update = cmd.step && !more;
   assign out_free    = !out_valid_ff || rsp_ready;
   assign out_load    = (emit && stage_valid_ff) || cmd.flush;

   assign status.radius_ok  = !req_item.radius[COORD_W-1] && (req_item.radius != '0) &&
                              (req_item.radius <= COORD_W'(MAX_RADIUS));
   assign status.stage_busy = stage_valid_ff && !out_free;
   assign status.walk_end   = !more && (cx_nxt > cy_nxt);
   assign status.out_free   = out_free;

   always_comb begin
      x_in           = x_ff;
      y_in           = y_ff;
      red_in         = red_ff;
      green_in       = green_ff;
      blue_in        = blue_ff;
      alpha_in       = alpha_ff;
      cx_in          = cx_ff;
      cy_in          = cy_ff;
      df_in          = df_ff;
      de_in          = de_ff;
      dse_in         = dse_ff;
      top_pend_in    = top_pend_ff;
      phase_in       = phase_ff;
      stage_in       = stage_ff;
      stage_valid_in = stage_valid_ff;
      if (cmd.load) begin
         x_in               = req_item.center_x;
         y_in               = req_item.center_y;
         red_in             = req_item.red;
         green_in           = req_item.green;
         blue_in            = req_item.blue;
         alpha_in           = req_item.alpha;
         cx_in              = '0;
         cy_in              = CNT_W'(req_item.radius);
         df_in              = WALK_W'(1) - r_walk;
         de_in              = WALK_W'(3);
         dse_in             = WALK_W'(5) - (r_walk <<< 1);
         top_pend_in        = 1'b1;
         phase_in           = PH_TOP;
         stage_in           = '0;
         stage_in.rejected  = 1'b1;
         stage_in.last_span = 1'b1;
         stage_valid_in     = !status.radius_ok;
      end else begin
         if (emit) begin
            stage_in       = new_span;
            stage_valid_in = 1'b1;
         end else if (cmd.flush) begin
            stage_valid_in = 1'b0;
         end
         if (cmd.step) begin
            phase_in = more ? sel + 1'b1 : PH_TOP;
         end
         if (walk_update) begin
            cx_in       = cx_nxt;
            cy_in       = cy_nxt;
            de_in       = de_ff + WALK_W'(2);
            top_pend_in = !df_ff[WALK_W-1];
            if (df_ff[WALK_W-1]) begin
               df_in  = df_ff + de_ff;
               dse_in = dse_ff + WALK_W'(2);
            end else begin
               df_in  = df_ff + dse_ff;
               dse_in = dse_ff + WALK_W'(4);
            end
         end
      end
   end

   always_comb begin
      out_in = out_ff;
      if (out_load) begin
         out_in           = stage_ff;
         out_in.last_span = cmd.flush;
      end
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
         phase_ff       <= PH_TOP;
      end else begin
         stage_valid_ff <= stage_valid_in;
         out_valid_ff   <= out_valid_in;
         phase_ff       <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      y_ff        <= y_in;
      red_ff      <= red_in;
      green_ff    <= green_in;
      blue_ff     <= blue_in;
      alpha_ff    <= alpha_in;
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      df_ff       <= df_in;
      de_ff       <= de_in;
      dse_ff      <= dse_in;
      top_pend_ff <= top_pend_in;
      stage_ff    <= stage_in;
      out_ff      <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_ff;

endmodule

### src/filled_circle_span_generator_top.sv
// Top level of the filled circle span generator: channels, controller and datapath.
`timescale 1ns / 1ps
// A circle command with radius r in 1..31 yields the horizontal spans that fill the disc,
// produced by a midpoint walk sequencer at one span per cycle while the result channel
// takes them; a walk step can yield no span, and a final flush marks last_span. A command
// with an invalid radius yields one transfer with rejected and last_span set. A new command
// is taken only after the previous one has been fully handed to the result register.
module filled_circle_span_generator_top (
   input logic        clock,
   input logic        reset,
   fcsg_req_if.sink   req_ch,
   fcsg_rsp_if.source rsp_ch
);
   import fcsg_pkg::*;

   circle_type req_item;
   span_type   rsp_item;
   cmd_type    cmd;
   status_type status;

   assign req_item.center_x = req_ch.center_x;
   assign req_item.center_y = req_ch.center_y;
   assign req_item.radius   = req_ch.radius;
   assign req_item.red      = req_ch.red;
   assign req_item.green    = req_ch.green;
   assign req_item.blue     = req_ch.blue;
   assign req_item.alpha    = req_ch.alpha;

   fcsg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   fcsg_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .rsp_item  (rsp_item)
   );

   assign rsp_ch.span_row   = rsp_item.span_row;
   assign rsp_ch.span_left  = rsp_item.span_left;
   assign rsp_ch.span_right = rsp_item.span_right;
   assign rsp_ch.out_red    = rsp_item.out_red;
   assign rsp_ch.out_green  = rsp_item.out_green;
   assign rsp_ch.out_blue   = rsp_item.out_blue;
   assign rsp_ch.out_alpha  = rsp_item.out_alpha;
   assign rsp_ch.rejected   = rsp_item.rejected;
   assign rsp_ch.last_span  = rsp_item.last_span;

`ifndef SYNTH
   a_one_command_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("Command transfer was followed by another ready cycle.");

   a_reject_is_final: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.rejected) |-> (rsp_ch.last_span && (rsp_ch.span_row == '0) &&
         (rsp_ch.out_alpha == '0)))
      else $error("Rejected result is not a clean final result.");

   a_stage_not_lost: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> !status.stage_busy)
      else $error("Walk advanced while the staged span could not move on.");

   a_quiet_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_ch.valid)
      else $error("Result valid right after reset.");
`endif

endmodule
